FILE: hdl/pdc_pkg.sv
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared constants, types and helper functions of the PD position controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pdc_pkg;

	localparam int unsigned GAIN_W   = 24;
	localparam int unsigned CFG_W    = 24;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned HEAD_W   = 19;
	localparam int unsigned VEL_W    = 42;

	localparam logic signed [20:0] PI_Q       = 21'sd205887;
	localparam logic signed [20:0] TWO_PI_Q   = 21'sd411775;
	localparam logic [23:0]        MAX_YAW_RATE = 24'd102944;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LIN_PROP  = 3'd0,
		CFG_LIN_DIFF  = 3'd1,
		CFG_YAW_PROP  = 3'd2,
		CFG_YAW_DIFF  = 3'd3,
		CFG_ARR_DIST  = 3'd4,
		CFG_ARR_HEAD  = 3'd5,
		CFG_MAX_HORZ  = 3'd6,
		CFG_MAX_VERT  = 3'd7
	} cfg_idx_t;

	// item function codes
	typedef enum logic [1:0] {
		FN_ODOM     = 2'd0,
		FN_GOAL     = 2'd1,
		FN_OVERRIDE = 2'd2,
		FN_TICK     = 2'd3
	} func_t;

	typedef enum logic {
		DS_SQRT = 1'b0,
		DS_DIV  = 1'b1
	} ds_op_t;

	typedef struct packed {
		logic   start;
		ds_op_t op;
	} ds_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} ds_stat_t;

	typedef enum logic [17:0] {
		ST_IDLE    = 18'b000000000000000001,
		ST_ARR_SQ  = 18'b000000000000000010,
		ST_ARR_ACC = 18'b000000000000000100,
		ST_ARR_THR = 18'b000000000000001000,
		ST_ARR_CMP = 18'b000000000000010000,
		ST_PD_P    = 18'b000000000000100000,
		ST_PD_D    = 18'b000000000001000000,
		ST_PD_SUM  = 18'b000000000010000000,
		ST_HZ_SH   = 18'b000000000100000000,
		ST_HZ_A    = 18'b000000001000000000,
		ST_HZ_B    = 18'b000000010000000000,
		ST_HZ_L    = 18'b000000100000000000,
		ST_HZ_CMP  = 18'b000001000000000000,
		ST_SQRT    = 18'b000010000000000000,
		ST_DIV_MUL = 18'b000100000000000000,
		ST_DIV_ST  = 18'b001000000000000000,
		ST_DIV_RUN = 18'b010000000000000000,
		ST_FIN     = 18'b100000000000000000
	} state_t;

	// heading difference folded once into plus/minus pi
	function automatic logic signed [20:0] wrap_pi(input logic signed [19:0] d);
		logic signed [20:0] w;
		w = 21'(d);
		if (w > PI_Q)
			w = w - TWO_PI_Q;
		else if (w < -PI_Q)
			w = w + TWO_PI_Q;
		return w;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v > 33'sh0_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -33'sh0_8000_0000)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] clamp_mag(input logic signed [VEL_W-1:0] v,
			input logic [23:0] lim);
		logic signed [VEL_W-1:0] l;
		logic signed [31:0] r;
		l = VEL_W'(signed'({1'b0, lim}));
		if (v > l)
			r = 32'(l);
		else if (v < -l)
			r = 32'(-l);
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/pdc_if.sv
// ----------------------------------------------------------------------------
// pdc_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdc_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [18:0] heading;

	modport source (output valid, func, pos_x, pos_y, pos_z, heading, input ready);
	modport sink (input valid, func, pos_x, pos_y, pos_z, heading, output ready);
endinterface

interface pdc_result_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic               accepted;
	logic               arrived;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic signed [31:0] vel_z;
	logic signed [31:0] yaw_rate;

	modport source (output valid, kind, accepted, arrived, vel_x, vel_y, vel_z, yaw_rate,
		input ready);
	modport sink (input valid, kind, accepted, arrived, vel_x, vel_y, vel_z, yaw_rate,
		output ready);
endinterface

`default_nettype wire

FILE: hdl/pdc_mul.sv
// ----------------------------------------------------------------------------
// pdc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module pdc_mul import pdc_pkg::*; (
	input  wire logic               clk,
	input  wire logic signed [31:0] a,
	input  wire logic signed [33:0] b,
	output logic signed [65:0]      p
);

	always_ff @(posedge clk) begin
		p <= 66'(a) * 66'(b);
	end

endmodule

`default_nettype wire

FILE: hdl/pdc_divsqrt.sv
// ----------------------------------------------------------------------------
// pdc_divsqrt
// Radix-2 iterative unit: integer square root or unsigned divide, one
// digit per cycle on a shared subtractor.
// ----------------------------------------------------------------------------
`default_nettype none

module pdc_divsqrt import pdc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ds_ctrl_t    ctrl,
	input  wire logic [63:0] x,
	input  wire logic [31:0] d,
	output ds_stat_t         stat,
	output logic [63:0]      res
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	ds_op_t      op_q;
	logic [63:0] x_q;
	logic [31:0] d_q;
	logic [34:0] rem_q;
	logic [63:0] res_q;

	logic [34:0] rem_in;
	logic [34:0] trial;
	logic        ge;

	always_comb begin
		if (op_q == DS_SQRT) begin
			rem_in = {rem_q[32:0], x_q[63:62]};
			trial  = {res_q[32:0], 2'b01};
		end else begin
			rem_in = {rem_q[33:0], x_q[63]};
			trial  = {3'b000, d_q};
		end
		ge = rem_in >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctrl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= (ctrl.op == DS_SQRT) ? 6'd31 : 6'd63;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
			cnt_q <= cnt_q - 6'd1;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			op_q  <= ctrl.op;
			x_q   <= x;
			d_q   <= d;
			rem_q <= '0;
			res_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (rem_in - trial) : rem_in;
			res_q <= {res_q[62:0], ge};
			x_q   <= (op_q == DS_SQRT) ? {x_q[61:0], 2'b00} : {x_q[62:0], 1'b0};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign res       = res_q;

endmodule

`default_nettype wire

FILE: hdl/pd_position_velocity_controller_unit.sv
// ----------------------------------------------------------------------------
// pd_position_velocity_controller_unit
// Four-axis PD position controller with horizontal speed scaling and
// vertical / yaw clamps, run by a sequencer over one multiplier and one
// shift-subtract square root / divide unit.
// ----------------------------------------------------------------------------
// odometry and goal items are handled on intake; a goal answer shows
// the cycle after the goal is taken; a control tick runs the arrival
// check when a goal is active, the PD terms of each axis, and, when the
// horizontal limit applies, a 32-step root and two 64-step divides
// one item at a time: no new item is taken while a result waits
// arst_n clears pose, goal state and status and loads register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module pd_position_velocity_controller_unit import pdc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	pdc_item_if.sink                  item,
	pdc_result_if.source              result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	// configuration
	logic [23:0] lin_prop_q, lin_diff_q, yaw_prop_q, yaw_diff_q;
	logic [23:0] arr_dist_q, max_horz_q, max_vert_q;
	logic [17:0] arr_head_q;

	// controller state
	logic signed [31:0] tgt_q  [4];
	logic signed [31:0] cur_q  [4];
	logic signed [31:0] prev_q [4];
	logic               odo_seen_q, goal_active_q, ever_goal_q;

	// sequencer and work registers
	state_t                  state_q;
	logic [1:0]              idx_q;
	logic [63:0]             acc_q;
	logic signed [31:0]      e_q;
	logic signed [VEL_W-1:0] v_q [4];
	logic                    fail_q, arr_q, shf_q;
	logic [30:0]             a_q, b_q;
	logic [31:0]             n_q;

	// result register
	logic               out_valid_q;
	logic               kind_q, acc_flag_q, arrived_q;
	logic signed [31:0] vx_q, vy_q, vz_q, yr_q;

	logic signed [31:0] mul_a;
	logic signed [33:0] mul_b;
	logic signed [65:0] prod;
	ds_ctrl_t           ds_ctrl;
	ds_stat_t           ds_stat;
	logic [63:0]        ds_x;
	logic [63:0]        ds_res;

	logic                    take;
	logic signed [31:0]      p_in [4];
	logic signed [32:0]      diff;
	logic [32:0]             amag;
	logic signed [31:0]      err;
	logic signed [20:0]      hwrap;
	logic [20:0]             hmag;
	logic signed [32:0]      hdiff;
	logic [23:0]             kp, kd;
	logic signed [63:0]      pd_sum;
	logic [VEL_W-1:0]        ax, ay, am;
	logic [3:0]              sh;
	logic [VEL_W-1:0]        ash, bsh;
	logic                    hz_need;
	logic [VEL_W-1:0]        quo;

	assign take = item.valid && item.ready;
	assign item.ready = (state_q == ST_IDLE) && !out_valid_q;

	assign p_in[0] = item.pos_x;
	assign p_in[1] = item.pos_y;
	assign p_in[2] = item.pos_z;
	assign p_in[3] = 32'(item.heading);

	// per-axis error at the current index
	always_comb begin
		diff  = 33'(tgt_q[idx_q]) - 33'(cur_q[idx_q]);
		amag  = diff[32] ? 33'(-diff) : 33'(diff);
		hdiff = 33'(tgt_q[3]) - 33'(cur_q[3]);
		hwrap = wrap_pi(hdiff[19:0]);
		hmag  = hwrap[20] ? 21'(-hwrap) : 21'(hwrap);
		if (idx_q == 2'd3)
			err = 32'(hwrap);
		else
			err = sat32(diff);
		kp = (idx_q == 2'd3) ? yaw_prop_q : lin_prop_q;
		kd = (idx_q == 2'd3) ? yaw_diff_q : lin_diff_q;
		pd_sum = signed'(acc_q) + signed'(prod[63:0]);
	end

	// horizontal pre-shift so both magnitudes fit 31 bits
	always_comb begin
		ax = v_q[0][VEL_W-1] ? VEL_W'(-v_q[0]) : VEL_W'(v_q[0]);
		ay = v_q[1][VEL_W-1] ? VEL_W'(-v_q[1]) : VEL_W'(v_q[1]);
		am = ax | ay;
		sh = '0;
		for (int k = 31; k < VEL_W; k++) begin
			if (am[k])
				sh = 4'(k - 30);
		end
		ash = ax >> sh;
		bsh = ay >> sh;
		hz_need = shf_q || (acc_q > prod[63:0]);
		quo = VEL_W'(ds_res[VEL_W-2:0]);
	end

	// multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_ARR_SQ: begin
				mul_a = signed'(amag[31:0]);
				mul_b = signed'({1'b0, amag});
			end
			ST_ARR_THR: begin
				mul_a = signed'({8'b0, arr_dist_q});
				mul_b = signed'({10'b0, arr_dist_q});
			end
			ST_PD_P: begin
				mul_a = signed'({8'b0, kp});
				mul_b = 34'(err);
			end
			ST_PD_D: begin
				mul_a = signed'({8'b0, kd});
				mul_b = 34'(e_q) - 34'(prev_q[idx_q]);
			end
			ST_HZ_A: begin
				mul_a = signed'({1'b0, a_q});
				mul_b = signed'({3'b0, a_q});
			end
			ST_HZ_B: begin
				mul_a = signed'({1'b0, b_q});
				mul_b = signed'({3'b0, b_q});
			end
			ST_HZ_L: begin
				mul_a = signed'({8'b0, max_horz_q});
				mul_b = signed'({10'b0, max_horz_q});
			end
			ST_DIV_MUL: begin
				mul_a = signed'({8'b0, max_horz_q});
				mul_b = signed'({3'b0, (idx_q == 2'd0) ? a_q : b_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		ds_ctrl.start = ((state_q == ST_HZ_CMP) && hz_need) || (state_q == ST_DIV_ST);
		ds_ctrl.op    = (state_q == ST_HZ_CMP) ? DS_SQRT : DS_DIV;
		ds_x          = (state_q == ST_HZ_CMP) ? acc_q : {9'b0, prod[54:0]};
	end

	pdc_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	pdc_divsqrt u_divsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ds_ctrl),
		.x      (ds_x),
		.d      (n_q),
		.stat   (ds_stat),
		.res    (ds_res)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_prop_q <= 24'd32768;
			lin_diff_q <= 24'd6554;
			yaw_prop_q <= 24'd32768;
			yaw_diff_q <= 24'd6554;
			arr_dist_q <= 24'd65536;
			arr_head_q <= 18'd114;
			max_horz_q <= 24'd327680;
			max_vert_q <= 24'd327680;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_LIN_PROP: lin_prop_q <= cfg_data;
				CFG_LIN_DIFF: lin_diff_q <= cfg_data;
				CFG_YAW_PROP: yaw_prop_q <= cfg_data;
				CFG_YAW_DIFF: yaw_diff_q <= cfg_data;
				CFG_ARR_DIST: arr_dist_q <= cfg_data;
				CFG_ARR_HEAD: arr_head_q <= cfg_data[17:0];
				CFG_MAX_HORZ: max_horz_q <= cfg_data;
				CFG_MAX_VERT: max_vert_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer, pose and goal state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			idx_q         <= '0;
			odo_seen_q    <= 1'b0;
			goal_active_q <= 1'b0;
			ever_goal_q   <= 1'b0;
			out_valid_q   <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				tgt_q[i]  <= '0;
				cur_q[i]  <= '0;
				prev_q[i] <= '0;
			end
		end else begin
			if (result.valid && result.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						case (func_t'(item.func))
							FN_ODOM: begin
								for (int i = 0; i < 4; i++)
									cur_q[i] <= p_in[i];
								odo_seen_q <= 1'b1;
							end
							FN_GOAL, FN_OVERRIDE: begin
								ever_goal_q <= 1'b1;
								out_valid_q <= 1'b1;
								if (!goal_active_q || item.func == FN_OVERRIDE) begin
									for (int i = 0; i < 4; i++) begin
										tgt_q[i]  <= p_in[i];
										prev_q[i] <= '0;
									end
									goal_active_q <= 1'b1;
								end
							end
							default: begin
								idx_q <= '0;
								if (odo_seen_q) begin
									if (goal_active_q)
										state_q <= ST_ARR_SQ;
									else if (ever_goal_q)
										state_q <= ST_PD_P;
								end
							end
						endcase
					end
				end
				ST_ARR_SQ:  state_q <= ST_ARR_ACC;
				ST_ARR_ACC: begin
					if (idx_q == 2'd2) begin
						state_q <= ST_ARR_THR;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= ST_ARR_SQ;
					end
				end
				ST_ARR_THR: state_q <= ST_ARR_CMP;
				ST_ARR_CMP: begin
					if (!fail_q && (acc_q < prod[63:0]) && (hmag < {3'b0, arr_head_q}))
						goal_active_q <= 1'b0;
					idx_q   <= '0;
					state_q <= ever_goal_q ? ST_PD_P : ST_IDLE;
				end
				ST_PD_P: state_q <= ST_PD_D;
				ST_PD_D: state_q <= ST_PD_SUM;
				ST_PD_SUM: begin
					prev_q[idx_q] <= e_q;
					if (idx_q == 2'd3) begin
						state_q <= ST_HZ_SH;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= ST_PD_P;
					end
				end
				ST_HZ_SH: state_q <= ST_HZ_A;
				ST_HZ_A:  state_q <= ST_HZ_B;
				ST_HZ_B:  state_q <= ST_HZ_L;
				ST_HZ_L:  state_q <= ST_HZ_CMP;
				ST_HZ_CMP: state_q <= hz_need ? ST_SQRT : ST_FIN;
				ST_SQRT: begin
					if (ds_stat.done) begin
						idx_q   <= '0;
						state_q <= ST_DIV_MUL;
					end
				end
				ST_DIV_MUL: state_q <= ST_DIV_ST;
				ST_DIV_ST:  state_q <= ST_DIV_RUN;
				ST_DIV_RUN: begin
					if (ds_stat.done) begin
						if (idx_q == 2'd0) begin
							idx_q   <= 2'd1;
							state_q <= ST_DIV_MUL;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// work registers and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				acc_q  <= '0;
				fail_q <= 1'b0;
				arr_q  <= 1'b0;
				if (take) begin
					kind_q     <= 1'b0;
					arrived_q  <= 1'b0;
					acc_flag_q <= (item.func == FN_OVERRIDE) || !goal_active_q;
					vx_q <= '0;
					vy_q <= '0;
					vz_q <= '0;
					yr_q <= '0;
				end
			end
			ST_ARR_SQ: begin
				if (amag >= {9'b0, arr_dist_q})
					fail_q <= 1'b1;
			end
			ST_ARR_ACC: acc_q <= acc_q + prod[63:0];
			ST_ARR_CMP: begin
				arr_q <= !fail_q && (acc_q < prod[63:0]) && (hmag < {3'b0, arr_head_q});
			end
			ST_PD_P: e_q <= err;
			ST_PD_D: acc_q <= prod[63:0];
			ST_PD_SUM: v_q[idx_q] <= pd_sum[VEL_W+15:16];
			ST_HZ_SH: begin
				a_q   <= ash[30:0];
				b_q   <= bsh[30:0];
				shf_q <= sh != '0;
			end
			ST_HZ_B: acc_q <= prod[63:0];
			ST_HZ_L: acc_q <= acc_q + prod[63:0];
			ST_SQRT: begin
				if (ds_stat.done)
					n_q <= (ds_res[31:0] == '0) ? 32'd1 : ds_res[31:0];
			end
			ST_DIV_RUN: begin
				if (ds_stat.done)
					v_q[idx_q] <= v_q[idx_q][VEL_W-1] ? VEL_W'(-signed'(quo)) : signed'(quo);
			end
			ST_FIN: begin
				kind_q     <= 1'b1;
				acc_flag_q <= 1'b0;
				arrived_q  <= arr_q;
				vx_q <= v_q[0][31:0];
				vy_q <= v_q[1][31:0];
				vz_q <= clamp_mag(v_q[2], max_vert_q);
				yr_q <= clamp_mag(v_q[3], MAX_YAW_RATE);
			end
			default: ;
		endcase
	end

	assign result.valid    = out_valid_q;
	assign result.kind     = kind_q;
	assign result.accepted = acc_flag_q;
	assign result.arrived  = arrived_q;
	assign result.vel_x    = vx_q;
	assign result.vel_y    = vy_q;
	assign result.vel_z    = vz_q;
	assign result.yaw_rate = yr_q;

endmodule

`default_nettype wire

FILE: hdl/pdc_checker.sv
// ----------------------------------------------------------------------------
// pdc_checker
// Port-level checks of the controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pdc_port_checks import pdc_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        item_valid,
	input wire logic        item_ready,
	input wire logic [1:0]  item_func,
	input wire logic        result_valid,
	input wire logic        result_ready,
	input wire logic        result_kind,
	input wire logic        result_accepted,
	input wire logic        result_arrived,
	input wire logic [31:0] result_vel_x,
	input wire logic [31:0] result_yaw_rate
);

	// held result must stay until its transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped before transfer");

	// an override goal is always answered with an accept next cycle
	a_override: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_func == FN_OVERRIDE |=>
		result_valid && !result_kind && result_accepted)
		else $error("override goal not accepted");

	// goal answers carry no motion
	a_answer: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_kind |->
		!result_arrived && result_vel_x == '0 && result_yaw_rate == '0)
		else $error("goal answer carries a command");

	a_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind |-> !result_accepted)
		else $error("command flagged as accepted goal");

	// no new item while a result waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !item_ready)
		else $error("item taken while result pending");

endmodule

bind pd_position_velocity_controller_unit pdc_port_checks u_pdc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.item_valid      (item.valid),
	.item_ready      (item.ready),
	.item_func       (item.func),
	.result_valid    (result.valid),
	.result_ready    (result.ready),
	.result_kind     (result.kind),
	.result_accepted (result.accepted),
	.result_arrived  (result.arrived),
	.result_vel_x    (result.vel_x),
	.result_yaw_rate (result.yaw_rate)
);

`default_nettype wire
